@@ hdl/pre_pkg.sv @@
// Shared constants and types for the page replacement engine.
package pre_pkg;

   localparam int NUM_FRAMES_DEF  = 16;
   localparam int PAGE_BITS_DEF   = 20;
   localparam int STAMP_BITS_DEF  = 32;

   localparam int FRAME_OUT_BITS  = 4;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLICY_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES_IN_USE = 2'd1;

   localparam logic [1:0] POLICY_FIFO  = 2'd0;
   localparam logic [1:0] POLICY_LRU   = 2'd1;
   localparam logic [1:0] POLICY_CLOCK = 2'd2;

   localparam logic [1:0] POLICY_RESET = POLICY_FIFO;
   localparam logic [4:0] FRAMES_RESET = 5'd16;

   typedef struct packed {
      logic [1:0] policy_mode;
      logic [4:0] frames_in_use;
   } cfg_type;

endpackage

@@ hdl/page_replacement_engine_unit.sv @@
// Top level of the page replacement engine: CSRs, sequencer and frame table.
//
//  channel  dir  handshake             word
//  req      in   req_valid/req_ready   req_page_number
//  rsp      out  rsp_valid/rsp_ready   hit, frame_index, filled_empty, evicted, victim_page
//  csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// One word at a time. The lookup scan reads the filled frames, one table read a cycle; the
// response is registered at commit, and the next request is taken once back in idle. A
// Clock second chance scan reads one frame a cycle and writes back the one before it
// through the separate write port.
// Reset needs no clearing pass: only filled frames are read. The next request is taken
// while a finished response waits; a stalled response holds the sequencer at commit.
module page_replacement_engine_unit #(
   parameter int NUM_FRAMES = pre_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = pre_pkg::PAGE_BITS_DEF,
   parameter int STAMP_BITS = pre_pkg::STAMP_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [PAGE_BITS-1:0]               req_page_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [pre_pkg::FRAME_OUT_BITS-1:0] rsp_frame_index,
   output logic                               rsp_filled_empty,
   output logic                               rsp_evicted,
   output logic [PAGE_BITS-1:0]               rsp_victim_page,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pre_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pre_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import pre_pkg::*;

   localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int WW = PAGE_BITS + STAMP_BITS + 1;

   cfg_type       cfg_ff, cfg_in;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [WW-1:0] rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_POLICY_MODE) begin
            cfg_in.policy_mode = csr_data[1:0];
         end else if (csr_index == CSR_FRAMES_IN_USE) begin
            cfg_in.frames_in_use = csr_data[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy_mode   <= POLICY_RESET;
         cfg_ff.frames_in_use <= FRAMES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pre_ctrl #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS),
      .IW         (IW),
      .WW         (WW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_filled_empty (rsp_filled_empty),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_page  (rsp_victim_page),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   pre_frame_ram #(
      .DEPTH (NUM_FRAMES),
      .WIDTH (WW),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

@@ hdl/pre_frame_ram.sv @@
// Frame table memory: one write port, one read port, registered read data.
module pre_frame_ram #(
   parameter int DEPTH = pre_pkg::NUM_FRAMES_DEF,
   parameter int WIDTH = pre_pkg::PAGE_BITS_DEF + pre_pkg::STAMP_BITS_DEF + 1,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pre_ctrl.sv @@
// Sequencer: lookup scan, victim selection, clock scan and result register.
module pre_ctrl #(
   parameter int NUM_FRAMES = pre_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = pre_pkg::PAGE_BITS_DEF,
   parameter int STAMP_BITS = pre_pkg::STAMP_BITS_DEF,
   parameter int IW         = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
   parameter int WW         = PAGE_BITS + STAMP_BITS + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pre_pkg::cfg_type                   cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [PAGE_BITS-1:0]               req_page_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [pre_pkg::FRAME_OUT_BITS-1:0] rsp_frame_index,
   output logic                               rsp_filled_empty,
   output logic                               rsp_evicted,
   output logic [PAGE_BITS-1:0]               rsp_victim_page,
   output logic                               rd_en,
   output logic [IW-1:0]                      rd_addr,
   input  logic [WW-1:0]                      rd_data,
   output logic                               wr_en,
   output logic [IW-1:0]                      wr_addr,
   output logic [WW-1:0]                      wr_data
);
   import pre_pkg::*;

   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int LW = (CW > 5) ? CW : 5;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOK   = 2'd1;
   localparam logic [1:0] S_CLK    = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         filled_ff, filled_in;
   logic [IW-1:0]         fifo_ff, fifo_in;
   logic [IW-1:0]         hand_ff, hand_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic                  got_v_ff, got_v_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [CW-1:0]         iss_ff, iss_in;
   logic [IW-1:0]         got_idx_ff, got_idx_in;
   logic [IW-1:0]         best_idx_ff, best_idx_in;
   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [PAGE_BITS-1:0]  best_page_ff, best_page_in;
   logic                  best_ref_ff, best_ref_in;
   logic [STAMP_BITS-1:0] cap_stamp_ff, cap_stamp_in;
   logic [PAGE_BITS-1:0]  cap_page_ff, cap_page_in;
   logic                  cap_ref_ff, cap_ref_in;
   logic [IW-1:0]         wr_idx_ff, wr_idx_in;
   logic [WW-1:0]         wr_word_ff, wr_word_in;
   logic                  res_hit_ff, res_hit_in;
   logic [IW-1:0]         res_idx_ff, res_idx_in;
   logic                  res_fill_ff, res_fill_in;
   logic                  res_evict_ff, res_evict_in;
   logic [PAGE_BITS-1:0]  res_victim_ff, res_victim_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [IW-1:0]         rsp_idx_ff, rsp_idx_in;
   logic                  rsp_fill_ff, rsp_fill_in;
   logic                  rsp_evict_ff, rsp_evict_in;
   logic [PAGE_BITS-1:0]  rsp_victim_ff, rsp_victim_in;

   logic [PAGE_BITS-1:0]  rd_page;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic                  rd_ref;
   logic [STAMP_BITS-1:0] nstamp;
   logic [LW-1:0]         fiu_w;
   logic [CW-1:0]         limit;
   logic [IW-1:0]         fifo_eff;
   logic [IW-1:0]         hand_eff;
   logic [IW-1:0]         cap_idx;
   logic                  match;
   logic                  last;

   function automatic logic [IW-1:0] next_frame(input logic [IW-1:0] x,
                                                input logic [CW-1:0] n);
      logic [CW-1:0] s;
      s = CW'(x) + CW'(1);
      return (s == n) ? '0 : IW'(s);
   endfunction

   assign rd_page  = rd_data[WW-1 -: PAGE_BITS];
   assign rd_stamp = rd_data[STAMP_BITS:1];
   assign rd_ref   = rd_data[0];

   assign nstamp = (stamp_ff == '1) ? stamp_ff : stamp_ff + STAMP_BITS'(1);

   assign fiu_w = LW'(cfg.frames_in_use);
   assign limit = (fiu_w == '0) ? CW'(1) :
                  (fiu_w > LW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(fiu_w);

   assign fifo_eff = (CW'(fifo_ff) < filled_ff) ? fifo_ff : '0;
   assign hand_eff = (CW'(hand_ff) < filled_ff) ? hand_ff : '0;
   assign cap_idx  = (cfg.policy_mode == POLICY_CLOCK) ? hand_eff : fifo_eff;

   assign match = got_v_ff && (rd_page == page_ff);
   assign last  = got_v_ff && ((CW'(got_idx_ff) + CW'(1)) == filled_ff);

   always_comb begin
      state_in      = state_ff;
      filled_in     = filled_ff;
      fifo_in       = fifo_ff;
      hand_in       = hand_ff;
      stamp_in      = stamp_ff;
      got_v_in      = 1'b0;
      got_idx_in    = got_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      page_in       = page_ff;
      iss_in        = iss_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_page_in  = best_page_ff;
      best_ref_in   = best_ref_ff;
      cap_stamp_in  = cap_stamp_ff;
      cap_page_in   = cap_page_ff;
      cap_ref_in    = cap_ref_ff;
      wr_idx_in     = wr_idx_ff;
      wr_word_in    = wr_word_ff;
      res_hit_in    = res_hit_ff;
      res_idx_in    = res_idx_ff;
      res_fill_in   = res_fill_ff;
      res_evict_in  = res_evict_ff;
      res_victim_in = res_victim_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_victim_in = rsp_victim_ff;
      rd_en         = 1'b0;
      rd_addr       = iss_ff[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = wr_idx_ff;
      wr_data       = wr_word_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in  = req_page_number;
               iss_in   = '0;
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            if (iss_ff < filled_ff) begin
               rd_en      = 1'b1;
               got_v_in   = 1'b1;
               got_idx_in = iss_ff[IW-1:0];
               iss_in     = iss_ff + CW'(1);
            end
            if (got_v_ff) begin
               if ((got_idx_ff == '0) || (rd_stamp < best_stamp_ff)) begin
                  best_idx_in   = got_idx_ff;
                  best_stamp_in = rd_stamp;
                  best_page_in  = rd_page;
                  best_ref_in   = rd_ref;
               end
               if (got_idx_ff == cap_idx) begin
                  cap_stamp_in = rd_stamp;
                  cap_page_in  = rd_page;
                  cap_ref_in   = rd_ref;
               end
            end
            res_hit_in    = 1'b0;
            res_fill_in   = 1'b0;
            res_evict_in  = 1'b0;
            res_victim_in = '0;
            if (match) begin
               got_v_in   = 1'b0;
               stamp_in   = nstamp;
               wr_idx_in  = got_idx_ff;
               wr_word_in = {page_ff, nstamp, 1'b1};
               res_hit_in = 1'b1;
               res_idx_in = got_idx_ff;
               state_in   = S_COMMIT;
            end else if ((filled_ff == '0) || last) begin
               got_v_in = 1'b0;
               state_in = S_COMMIT;
               if (filled_ff < limit) begin
                  stamp_in    = nstamp;
                  wr_idx_in   = IW'(filled_ff);
                  wr_word_in  = {page_ff, nstamp, 1'b1};
                  filled_in   = filled_ff + CW'(1);
                  hand_in     = '0;
                  res_fill_in = 1'b1;
                  res_idx_in  = IW'(filled_ff);
               end else if (cfg.policy_mode == POLICY_LRU) begin
                  stamp_in      = nstamp;
                  wr_idx_in     = best_idx_in;
                  wr_word_in    = {page_ff, nstamp, best_ref_in};
                  res_evict_in  = 1'b1;
                  res_idx_in    = best_idx_in;
                  res_victim_in = best_page_in;
               end else if (cfg.policy_mode == POLICY_CLOCK) begin
                  if (!cap_ref_in || (next_frame(hand_eff, filled_ff) == hand_eff)) begin
                     wr_idx_in     = hand_eff;
                     wr_word_in    = {page_ff, cap_stamp_in, 1'b1};
                     hand_in       = next_frame(hand_eff, filled_ff);
                     res_evict_in  = 1'b1;
                     res_idx_in    = hand_eff;
                     res_victim_in = cap_page_in;
                  end else begin
                     iss_in   = CW'(next_frame(hand_eff, filled_ff));
                     state_in = S_CLK;
                  end
               end else begin
                  wr_idx_in     = fifo_eff;
                  wr_word_in    = {page_ff, cap_stamp_in, cap_ref_in};
                  fifo_in       = next_frame(fifo_eff, filled_ff);
                  res_evict_in  = 1'b1;
                  res_idx_in    = fifo_eff;
                  res_victim_in = cap_page_in;
               end
            end
         end

         S_CLK: begin
            if (iss_ff[IW-1:0] != hand_eff) begin
               rd_en      = 1'b1;
               got_v_in   = 1'b1;
               got_idx_in = iss_ff[IW-1:0];
               iss_in     = CW'(next_frame(iss_ff[IW-1:0], filled_ff));
            end
            if (got_v_ff) begin
               if (!rd_ref) begin
                  got_v_in      = 1'b0;
                  wr_idx_in     = got_idx_ff;
                  wr_word_in    = {page_ff, rd_stamp, 1'b1};
                  hand_in       = next_frame(got_idx_ff, filled_ff);
                  res_evict_in  = 1'b1;
                  res_idx_in    = got_idx_ff;
                  res_victim_in = rd_page;
                  state_in      = S_COMMIT;
               end else begin
                  // second chance: clear the bit and move on
                  wr_en   = 1'b1;
                  wr_addr = got_idx_ff;
                  wr_data = {rd_page, rd_stamp, 1'b0};
                  if (next_frame(got_idx_ff, filled_ff) == hand_eff) begin
                     got_v_in      = 1'b0;
                     wr_idx_in     = hand_eff;
                     wr_word_in    = {page_ff, cap_stamp_ff, 1'b1};
                     hand_in       = next_frame(hand_eff, filled_ff);
                     res_evict_in  = 1'b1;
                     res_idx_in    = hand_eff;
                     res_victim_in = cap_page_ff;
                     state_in      = S_COMMIT;
                  end
               end
            end
         end

         S_COMMIT: begin
            wr_en = 1'b1;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_fill_in   = res_fill_ff;
               rsp_evict_in  = res_evict_ff;
               rsp_victim_in = res_victim_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         fifo_ff      <= '0;
         hand_ff      <= '0;
         stamp_ff     <= '0;
         got_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         fifo_ff      <= fifo_in;
         hand_ff      <= hand_in;
         stamp_ff     <= stamp_in;
         got_v_ff     <= got_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      iss_ff        <= iss_in;
      got_idx_ff    <= got_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_page_ff  <= best_page_in;
      best_ref_ff   <= best_ref_in;
      cap_stamp_ff  <= cap_stamp_in;
      cap_page_ff   <= cap_page_in;
      cap_ref_ff    <= cap_ref_in;
      wr_idx_ff     <= wr_idx_in;
      wr_word_ff    <= wr_word_in;
      res_hit_ff    <= res_hit_in;
      res_idx_ff    <= res_idx_in;
      res_fill_ff   <= res_fill_in;
      res_evict_ff  <= res_evict_in;
      res_victim_ff <= res_victim_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_index  = FRAME_OUT_BITS'(rsp_idx_ff);
   assign rsp_filled_empty = rsp_fill_ff;
   assign rsp_evicted      = rsp_evict_ff;
   assign rsp_victim_page  = rsp_victim_ff;

endmodule

@@ test/tb_page_replacement_engine_unit.sv @@
// Self-checking testbench for the page replacement engine: FIFO, LRU and Clock policies.
`timescale 1ns / 100ps

module tb_page_replacement_engine_unit;
   import pre_pkg::*;

   localparam int PW          = PAGE_BITS_DEF;
   localparam int NF          = NUM_FRAMES_DEF;
   localparam int SW          = STAMP_BITS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_GAP     = 13;

   localparam logic [1:0] POLICY_SPARE = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic          hit;
      logic [3:0]    frame_index;
      logic          filled_empty;
      logic          evicted;
      logic [PW-1:0] victim_page;
   } page_outcome_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [PW-1:0]             req_page_number;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_hit;
   logic [FRAME_OUT_BITS-1:0] rsp_frame_index;
   logic                      rsp_filled_empty;
   logic                      rsp_evicted;
   logic [PW-1:0]             rsp_victim_page;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   page_replacement_engine_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_filled_empty (rsp_filled_empty),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_page  (rsp_victim_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // frame table mirror
   logic [PW-1:0] tbl_page  [NF];
   logic [SW-1:0] tbl_stamp [NF];
   logic          tbl_ref   [NF];
   int            filled_cnt;
   int            fifo_ptr;
   int            clock_hand;
   logic [SW-1:0] stamp_ctr;
   logic [1:0]    cfg_policy;
   logic [4:0]    cfg_frames;

   page_outcome_type outcome_q[$];
   int            fail_count;
   int            cycle_count;
   bit            no_idle;
   int            rsp_gap;
   int            rsp_hold;
   logic [PW-1:0] page_pool[$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [SW-1:0] bump_stamp();
      if (stamp_ctr != '1)
         stamp_ctr = stamp_ctr + SW'(1);
      return stamp_ctr;
   endfunction

   function automatic int pick_fifo_victim();
      int v;
      v = (fifo_ptr < filled_cnt) ? fifo_ptr : 0;
      fifo_ptr = (v + 1) % filled_cnt;
      return v;
   endfunction

   function automatic int pick_lru_victim();
      int best;
      best = 0;
      for (int i = 1; i < filled_cnt; i++)
         if (tbl_stamp[i] < tbl_stamp[best])
            best = i;
      tbl_stamp[best] = bump_stamp();
      return best;
   endfunction

   function automatic int pick_clock_victim();
      int hand;
      int v;
      int t;
      hand = (clock_hand < filled_cnt) ? clock_hand : 0;
      v = hand;
      if (tbl_ref[hand]) begin
         t = (hand + 1) % filled_cnt;
         while (t != hand) begin
            if (!tbl_ref[t]) begin
               v = t;
               break;
            end
            tbl_ref[t] = 1'b0;
            t = (t + 1) % filled_cnt;
         end
      end
      tbl_ref[v] = 1'b1;
      clock_hand = (v + 1) % filled_cnt;
      return v;
   endfunction

   function automatic page_outcome_type resolve_reference(logic [PW-1:0] page);
      page_outcome_type o;
      int idx;
      int lim;
      bit found;
      o = '0;
      idx = 0;
      found = 1'b0;
      lim = (cfg_frames == 0) ? 1 : ((cfg_frames > NF) ? NF : int'(cfg_frames));
      for (int i = 0; i < filled_cnt; i++)
         if (!found && tbl_page[i] == page) begin
            found = 1'b1;
            idx = i;
         end
      if (found) begin
         o.hit = 1'b1;
         tbl_stamp[idx] = bump_stamp();
         tbl_ref[idx] = 1'b1;
      end else if (filled_cnt < lim) begin
         idx = filled_cnt;
         tbl_page[idx] = page;
         tbl_stamp[idx] = bump_stamp();
         tbl_ref[idx] = 1'b1;
         filled_cnt++;
         clock_hand = 0;
         o.filled_empty = 1'b1;
      end else begin
         if (cfg_policy == POLICY_LRU)
            idx = pick_lru_victim();
         else if (cfg_policy == POLICY_CLOCK)
            idx = pick_clock_victim();
         else
            idx = pick_fifo_victim();
         o.victim_page = tbl_page[idx];
         tbl_page[idx] = page;
         o.evicted = 1'b1;
      end
      o.frame_index = idx[3:0];
      return o;
   endfunction

   // entered and left at a falling edge; valid stays high for a back-to-back word
   task automatic send_page(input logic [PW-1:0] page);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
      outcome_q.push_back(resolve_reference(page));
      @(negedge clock);
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (outcome_q.size() > 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_POLICY_MODE)
         cfg_policy = data[1:0];
      else if (index == CSR_FRAMES_IN_USE)
         cfg_frames = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      page_outcome_type exp_o;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            $error("response word with nothing outstanding");
            fail_count++;
         end else begin
            exp_o = outcome_q.pop_front();
            if (rsp_hit !== exp_o.hit) begin
               $error("hit: expected %0d, got %0d", exp_o.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_frame_index !== exp_o.frame_index) begin
               $error("frame_index: expected %0d, got %0d", exp_o.frame_index,
                      rsp_frame_index);
               fail_count++;
            end
            if (rsp_filled_empty !== exp_o.filled_empty) begin
               $error("filled_empty: expected %0d, got %0d", exp_o.filled_empty,
                      rsp_filled_empty);
               fail_count++;
            end
            if (rsp_evicted !== exp_o.evicted) begin
               $error("evicted: expected %0d, got %0d", exp_o.evicted, rsp_evicted);
               fail_count++;
            end
            if (rsp_victim_page !== exp_o.victim_page) begin
               $error("victim_page: expected %h, got %h", exp_o.victim_page,
                      rsp_victim_page);
               fail_count++;
            end
         end
         rsp_gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_fifo_fill();
      write_register(CSR_POLICY_MODE, CSR_DATA_BITS'(POLICY_FIFO));
      write_register(CSR_FRAMES_IN_USE, 5'd0);
      send_page('0);
      send_page('1);
      send_page('1);
      drain_pending();
      write_register(CSR_FRAMES_IN_USE, 5'd3);
      write_register(CSR_POLICY_MODE, CSR_DATA_BITS'(POLICY_SPARE));
      send_page(20'h12345);
      send_page(20'h12345);
      send_page(20'hABCDE);
      send_page(20'h55555);
      drain_pending();
   endtask

   task automatic test_lru();
      write_register(CSR_POLICY_MODE, CSR_DATA_BITS'(POLICY_LRU));
      write_register(CSR_FRAMES_IN_USE, 5'd4);
      send_page(20'h00001);
      send_page(20'h12345);
      send_page(20'h77777);
      drain_pending();
   endtask

   task automatic test_clock();
      write_register(CSR_POLICY_MODE, CSR_DATA_BITS'(POLICY_CLOCK));
      write_register(CSR_FRAMES_IN_USE, 5'd5);
      send_page(20'h2AAAA);
      // every bit set: scan wraps to the hand
      send_page(20'h15555);
      send_page(20'h2AAAA);
      send_page(20'h0F0F0);
      drain_pending();
   endtask

   task automatic test_register_edges();
      write_register(CSR_FRAMES_IN_USE, 5'd31);
      write_register(CSR_SPARE_2, 5'd1);
      write_register(CSR_SPARE_3, 5'd31);
      send_page(20'h80000);
      send_page(20'h00008);
      drain_pending();
   endtask

   task automatic test_lowered_limit();
      write_register(CSR_POLICY_MODE, CSR_DATA_BITS'(POLICY_FIFO));
      write_register(CSR_FRAMES_IN_USE, 5'd2);
      send_page(20'h3C3C3);
      drain_pending();
      write_register(CSR_FRAMES_IN_USE, 5'd1);
      write_register(CSR_FRAMES_IN_USE, 5'd1);
      send_page(20'hC3C3C);
      drain_pending();
   endtask

   task automatic load_pool();
      int n;
      n = $urandom_range(2, 24);
      page_pool.delete();
      repeat (n) page_pool.push_back(PW'($urandom));
   endtask

   function automatic logic [PW-1:0] draw_page();
      if ($urandom_range(0, 9) < 8)
         return page_pool[$urandom_range(0, page_pool.size() - 1)];
      return PW'($urandom);
   endfunction

   task automatic test_random_traffic();
      for (int seg = 0; seg < 33; seg++) begin
         write_register(CSR_POLICY_MODE, CSR_DATA_BITS'($urandom_range(0, 3)));
         write_register(CSR_FRAMES_IN_USE, CSR_DATA_BITS'($urandom_range(0, 31)));
         if ($urandom_range(0, 5) == 0)
            write_register(($urandom_range(0, 1) == 0) ? CSR_SPARE_2 : CSR_SPARE_3,
                           CSR_DATA_BITS'($urandom));
         load_pool();
         no_idle = ($urandom_range(0, 4) == 0);
         repeat (50) send_page(draw_page());
         drain_pending();
         no_idle = 1'b0;
      end
   endtask

   task automatic test_output_stall();
      write_register(CSR_POLICY_MODE, CSR_DATA_BITS'(POLICY_CLOCK));
      load_pool();
      no_idle = 1'b1;
      rsp_hold = 400;
      repeat (30) send_page(draw_page());
      drain_pending();
      no_idle = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_page_number = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      fail_count      = 0;
      no_idle         = 1'b0;
      rsp_gap         = 0;
      rsp_hold        = 0;
      filled_cnt      = 0;
      fifo_ptr        = 0;
      clock_hand      = 0;
      stamp_ctr       = '0;
      cfg_policy      = POLICY_RESET;
      cfg_frames      = FRAMES_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);
      test_fifo_fill();
      test_lru();
      test_clock();
      test_register_edges();
      test_lowered_limit();
      test_random_traffic();
      test_output_stall();
      drain_pending();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && outcome_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
